// File: design/ssd_pkg.sv
package ssd_pkg;

  localparam logic [1:0] LINES_RED   = 2'd1;
  localparam logic [1:0] LINES_GREEN = 2'd2;

  localparam logic [1:0] COLOUR_RED   = 2'd0;
  localparam logic [1:0] COLOUR_GREEN = 2'd1;

  localparam logic [1:0] MARKER_HIGH = 2'd1;
  localparam logic [1:0] MARKER_LOW  = 2'd2;

  localparam logic FUNC_NUMBER = 1'b0;

  localparam logic [3:0] SEG_BLANK_IDX = 4'd10;
  localparam logic [3:0] SEG_HIGH_IDX  = 4'd11;
  localparam logic [3:0] SEG_LOW_IDX   = 4'd12;

  localparam logic [7:0] SEG_BLANK = 8'hff;

  typedef struct packed {
    logic        func;
    logic [15:0] value;
    logic [1:0]  colour;
    logic [1:0]  marker;
    logic [3:0]  char_first;
    logic [3:0]  char_second;
    logic [3:0]  char_third;
    logic [3:0]  char_fourth;
  } cmd_t;

  typedef struct packed {
    logic       serial_bit;
    logic [1:0] lines_during;
    logic [1:0] lines_after;
    logic       last_bit;
  } seg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] value;
    logic [1:0]  marker;
    logic [15:0] chars;
    logic [1:0]  during;
    logic [1:0]  after;
  } stage1_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  thousands;
    logic [9:0]  rem;
    logic [1:0]  marker;
    logic [15:0] chars;
    logic [1:0]  during;
    logic [1:0]  after;
  } stage2_t;

  function automatic logic [7:0] digit_segs(input logic [3:0] idx);
    logic [7:0] s;
    case (idx)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      4'd11:   s = 8'hfe;
      4'd12:   s = 8'hf7;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] char_segs(input logic [3:0] idx);
    logic [7:0] s;
    case (idx)
      4'd0:    s = 8'h88;
      4'd1:    s = 8'h83;
      4'd2:    s = 8'hc6;
      4'd3:    s = 8'ha1;
      4'd4:    s = 8'h86;
      4'd5:    s = 8'h8e;
      4'd6:    s = 8'h90;
      4'd7:    s = 8'ha3;
      4'd8:    s = 8'ha1;
      4'd9:    s = 8'h89;
      4'd10:   s = 8'hc1;
      4'd11:   s = 8'h82;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // quotient digit of v by unit, valid while v < 10 * unit
  function automatic logic [3:0] quot_digit(input logic [15:0] v, input logic [15:0] unit);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({4'd0, v} >= 20'(k) * {4'd0, unit}) begin
        q = 4'(k);
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] rem_digit(input logic [15:0] v, input logic [15:0] unit,
                                            input logic [3:0] q);
    logic [19:0] p;
    p = {16'd0, q} * {4'd0, unit};
    return v - p[15:0];
  endfunction

endpackage

// File: design/seven_segment_serial_display_driver.sv
// An item passes s1, s2 and fr into the shift register before its first bit is offered.
// One serial bit per cycle while seg_ready is high, set by the output shift register.
// Items are accepted back to back into a three-deep staging pipeline while bits shift out.
// Reset (synchronous, active high) empties all stages and clears the held colour lines to low.
module seven_segment_serial_display_driver (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ssd_pkg::cmd_t      cmd,
  output logic               seg_valid,
  input  logic               seg_ready,
  output ssd_pkg::seg_t      seg
);
  import ssd_pkg::*;

  logic [1:0]  colour_lines;
  logic [1:0]  colour_lines_next;
  logic [1:0]  during_next;

  logic        s1_v;
  stage1_t     s1;
  logic        s2_v;
  stage2_t     s2;
  stage2_t     s2_next;
  logic        fr_v;
  logic [31:0] fr_word;
  logic [1:0]  fr_during;
  logic [1:0]  fr_after;
  logic [31:0] fr_word_next;

  logic        sh_v;
  logic [31:0] sh_word;
  logic [4:0]  sh_cnt;
  logic [1:0]  sh_during;
  logic [1:0]  sh_after;

  logic        sh_free;
  logic        fr_free;
  logic        s2_free;
  logic        cmd_take;

  assign sh_free   = !sh_v || (seg_ready && (&sh_cnt));
  assign fr_free   = !fr_v || sh_free;
  assign s2_free   = !s2_v || fr_free;
  assign cmd_ready = !s1_v || s2_free;
  assign cmd_take  = cmd_valid && cmd_ready;

  always_comb begin
    colour_lines_next = colour_lines;
    during_next       = colour_lines;
    if (cmd.func == FUNC_NUMBER) begin
      colour_lines_next = (cmd.colour == COLOUR_GREEN) ? LINES_GREEN : LINES_RED;
      during_next       = colour_lines_next;
    end else if (cmd.colour == COLOUR_RED) begin
      colour_lines_next = LINES_RED;
    end else if (cmd.colour == COLOUR_GREEN) begin
      colour_lines_next = LINES_GREEN;
    end
  end

  always_comb begin
    logic [3:0]  q10k;
    logic [15:0] v;
    logic [15:0] r;
    q10k              = quot_digit(s1.value, 16'd10000);
    v                 = rem_digit(s1.value, 16'd10000, q10k);
    s2_next.func      = s1.func;
    s2_next.thousands = quot_digit(v, 16'd1000);
    r                 = rem_digit(v, 16'd1000, s2_next.thousands);
    s2_next.rem       = r[9:0];
    s2_next.marker    = s1.marker;
    s2_next.chars     = s1.chars;
    s2_next.during    = s1.during;
    s2_next.after     = s1.after;
  end

  always_comb begin
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  d3;
    logic [15:0] r2;
    logic [15:0] r3;
    d0 = s2.thousands;
    d1 = quot_digit({6'd0, s2.rem}, 16'd100);
    r2 = rem_digit({6'd0, s2.rem}, 16'd100, d1);
    d2 = quot_digit(r2, 16'd10);
    r3 = rem_digit(r2, 16'd10, d2);
    d3 = r3[3:0];
    if (d0 == 4'd0) begin
      d0 = SEG_BLANK_IDX;
      if (d1 == 4'd0) begin
        if (s2.marker == MARKER_HIGH) begin
          d1 = SEG_HIGH_IDX;
        end else if (s2.marker == MARKER_LOW) begin
          d1 = SEG_LOW_IDX;
        end else begin
          d1 = SEG_BLANK_IDX;
        end
        if (d2 == 4'd0) begin
          d2 = SEG_BLANK_IDX;
        end
      end
    end
    if (s2.func == FUNC_NUMBER) begin
      fr_word_next = {digit_segs(d0), digit_segs(d1), digit_segs(d2), digit_segs(d3)};
    end else begin
      fr_word_next = {char_segs(s2.chars[15:12]), char_segs(s2.chars[11:8]),
                      char_segs(s2.chars[7:4]), char_segs(s2.chars[3:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_lines <= 2'd0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      fr_v         <= 1'b0;
      sh_v         <= 1'b0;
      sh_cnt       <= 5'd0;
    end else begin
      if (cmd_take) begin
        colour_lines <= colour_lines_next;
      end
      if (cmd_ready) begin
        s1_v <= cmd_valid;
      end
      if (s2_free) begin
        s2_v <= s1_v;
      end
      if (fr_free) begin
        fr_v <= s2_v;
      end
      if (sh_free) begin
        sh_v   <= fr_v;
        sh_cnt <= 5'd0;
      end else if (seg_ready) begin
        sh_cnt <= sh_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1.func   <= cmd.func;
      s1.value  <= cmd.value;
      s1.marker <= cmd.marker;
      s1.chars  <= {cmd.char_first, cmd.char_second, cmd.char_third, cmd.char_fourth};
      s1.during <= during_next;
      s1.after  <= colour_lines_next;
    end
    if (s1_v && s2_free) begin
      s2 <= s2_next;
    end
    if (s2_v && fr_free) begin
      fr_word   <= fr_word_next;
      fr_during <= s2.during;
      fr_after  <= s2.after;
    end
    if (sh_free) begin
      sh_word   <= fr_word;
      sh_during <= fr_during;
      sh_after  <= fr_after;
    end else if (seg_ready) begin
      sh_word <= {sh_word[30:0], 1'b0};
    end
  end

  assign seg_valid        = sh_v;
  assign seg.serial_bit   = sh_word[31];
  assign seg.lines_during = sh_during;
  assign seg.lines_after  = sh_after;
  assign seg.last_bit     = &sh_cnt;

endmodule

// File: dv/seven_segment_serial_display_driver_tb.sv
module seven_segment_serial_display_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 188;

  class display_bits_board;
    logic [1:0] colour_lines;
    logic [7:0] digit_glyph [16];
    logic [7:0] char_glyph [16];
    seg_t bits_due [$];
    int mismatches;
    int bits_seen;

    function new();
      colour_lines = 2'b00;
      mismatches = 0;
      bits_seen = 0;
      digit_glyph = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
                      8'h80, 8'h90, 8'hff, 8'hfe, 8'hf7, 8'hff, 8'hff, 8'hff};
      char_glyph = '{8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'h90, 8'ha3,
                     8'ha1, 8'h89, 8'hc1, 8'h82, 8'hff, 8'hff, 8'hff, 8'hff};
    endfunction

    function int pending();
      return bits_due.size();
    endfunction

    function void note_cmd(cmd_t c);
      logic [7:0] glyph [4];
      logic [3:0] d [4];
      logic [1:0] during;
      int unsigned v;
      seg_t s;
      during = colour_lines;
      if (c.func == FUNC_NUMBER) begin
        v = c.value % 10000;
        d[0] = 4'(v / 1000);
        d[1] = 4'((v / 100) % 10);
        d[2] = 4'((v / 10) % 10);
        d[3] = 4'(v % 10);
        if (d[0] == 4'd0) begin
          d[0] = SEG_BLANK_IDX;
          if (d[1] == 4'd0) begin
            if (c.marker == MARKER_HIGH) begin
              d[1] = SEG_HIGH_IDX;
            end else if (c.marker == MARKER_LOW) begin
              d[1] = SEG_LOW_IDX;
            end else begin
              d[1] = SEG_BLANK_IDX;
            end
            if (d[2] == 4'd0) begin
              d[2] = SEG_BLANK_IDX;
            end
          end
        end
        colour_lines = (c.colour == COLOUR_GREEN) ? LINES_GREEN : LINES_RED;
        during = colour_lines;
        for (int j = 0; j < 4; j++) begin
          glyph[j] = digit_glyph[d[j]];
        end
      end else begin
        glyph[0] = char_glyph[c.char_first];
        glyph[1] = char_glyph[c.char_second];
        glyph[2] = char_glyph[c.char_third];
        glyph[3] = char_glyph[c.char_fourth];
        if (c.colour == COLOUR_RED) begin
          colour_lines = LINES_RED;
        end else if (c.colour == COLOUR_GREEN) begin
          colour_lines = LINES_GREEN;
        end
      end
      for (int k = 0; k < 32; k++) begin
        s.serial_bit = glyph[k / 8][7 - (k % 8)];
        s.lines_during = during;
        s.lines_after = colour_lines;
        s.last_bit = (k == 31);
        bits_due.push_back(s);
      end
    endfunction

    function void check_bit(seg_t got);
      seg_t want;
      bits_seen++;
      if (bits_due.size() == 0) begin
        $display("%0t unexpected bit: expected none, actual %b", $time, got);
        mismatches++;
        return;
      end
      want = bits_due.pop_front();
      if (got.serial_bit !== want.serial_bit) begin
        $display("%0t serial_bit: expected %b, actual %b", $time, want.serial_bit,
                 got.serial_bit);
        mismatches++;
      end
      if (got.lines_during !== want.lines_during) begin
        $display("%0t lines_during: expected %b, actual %b", $time, want.lines_during,
                 got.lines_during);
        mismatches++;
      end
      if (got.lines_after !== want.lines_after) begin
        $display("%0t lines_after: expected %b, actual %b", $time, want.lines_after,
                 got.lines_after);
        mismatches++;
      end
      if (got.last_bit !== want.last_bit) begin
        $display("%0t last_bit: expected %b, actual %b", $time, want.last_bit,
                 got.last_bit);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic seg_valid;
  logic seg_ready = 1'b0;
  seg_t seg;

  display_bits_board board;
  bit steady = 1'b0;
  int n_number = 0;
  int n_chars = 0;
  int idle_cycles = 0;

  seven_segment_serial_display_driver DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst && seg_valid && seg_ready) begin
      board.check_bit(seg);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (seg_valid && seg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("seven_segment_serial_display_driver_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.func = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c.value = 16'($urandom_range(0, 65535));
      1: c.value = 16'($urandom_range(0, 99));
      2: c.value = 16'($urandom_range(0, 999));
      default: c.value = 16'($urandom_range(0, 6) * 10000 + $urandom_range(0, 120));
    endcase
    c.colour = 2'($urandom_range(0, 3));
    c.marker = 2'($urandom_range(0, 3));
    c.char_first = 4'($urandom_range(0, 15));
    c.char_second = 4'($urandom_range(0, 15));
    c.char_third = 4'($urandom_range(0, 15));
    c.char_fourth = 4'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic cmd_t number_cmd(int unsigned value, logic [1:0] colour,
                                      logic [1:0] marker);
    cmd_t c;
    c = random_cmd();
    c.func = FUNC_NUMBER;
    c.value = 16'(value);
    c.colour = colour;
    c.marker = marker;
    return c;
  endfunction

  function automatic cmd_t chars_cmd(logic [1:0] colour, logic [3:0] a, logic [3:0] b,
                                     logic [3:0] e, logic [3:0] f);
    cmd_t c;
    c = random_cmd();
    c.func = ~FUNC_NUMBER;
    c.colour = colour;
    c.char_first = a;
    c.char_second = b;
    c.char_third = e;
    c.char_fourth = f;
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    board.note_cmd(c);
    if (c.func == FUNC_NUMBER) begin
      n_number++;
    end else begin
      n_chars++;
    end
    @(negedge clk);
  endtask

  task automatic take_bit();
    int unsigned hold;
    hold = steady ? 0 : $urandom_range(0, 17);
    if (hold != 0) begin
      seg_ready <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    seg_ready <= 1'b1;
    do @(posedge clk); while (rst || !seg_valid);
    @(negedge clk);
  endtask

  initial begin
    board = new();
    @(negedge clk);
    forever take_bit();
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(chars_cmd(2'd2, 4'd0, 4'd1, 4'd2, 4'd3));
    send_cmd(number_cmd(0, COLOUR_RED, 2'd0));
    send_cmd(number_cmd(0, COLOUR_GREEN, MARKER_HIGH));
    send_cmd(number_cmd(0, 2'd2, MARKER_LOW));
    send_cmd(number_cmd(0, 2'd3, 2'd3));
    send_cmd(number_cmd(7, COLOUR_GREEN, MARKER_HIGH));
    send_cmd(number_cmd(45, COLOUR_RED, MARKER_LOW));
    send_cmd(number_cmd(100, COLOUR_GREEN, MARKER_HIGH));
    send_cmd(number_cmd(305, COLOUR_RED, MARKER_LOW));
    send_cmd(number_cmd(1000, COLOUR_GREEN, MARKER_HIGH));
    send_cmd(number_cmd(9999, COLOUR_RED, MARKER_LOW));
    send_cmd(number_cmd(10000, COLOUR_GREEN, MARKER_HIGH));
    send_cmd(number_cmd(10050, 2'd2, MARKER_LOW));
    send_cmd(number_cmd(65535, 2'd3, MARKER_HIGH));
    send_cmd(number_cmd(20007, COLOUR_GREEN, MARKER_LOW));
    send_cmd(chars_cmd(COLOUR_GREEN, 4'd4, 4'd5, 4'd6, 4'd7));
    send_cmd(chars_cmd(2'd3, 4'd8, 4'd9, 4'd10, 4'd11));
    send_cmd(chars_cmd(COLOUR_RED, 4'd12, 4'd13, 4'd14, 4'd15));
    send_cmd(chars_cmd(2'd2, 4'd15, 4'd0, 4'd12, 4'd3));
    send_cmd(number_cmd(1, COLOUR_GREEN, 2'd0));
    send_cmd(number_cmd(2009, COLOUR_RED, 2'd3));
    send_cmd(number_cmd(4096, 2'd2, MARKER_HIGH));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 70) || (i >= 150 && i < 175);
      if (i == 100) begin
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0) @(negedge clk);
      end
      send_cmd(random_cmd());
    end
    cmd_valid <= 1'b0;
    steady = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d number and %0d character commands, %0d serial bits checked",
             n_number, n_chars, board.bits_seen);
    $display("with random gaps on both channels, back-to-back stretches and one full drain");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("seven_segment_serial_display_driver_tb: clean");
    end else begin
      $display("seven_segment_serial_display_driver_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ssd_pkg.sv
design/seven_segment_serial_display_driver.sv
dv/seven_segment_serial_display_driver_tb.sv
